[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file bqmix_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/bqmix_pkg.sv]
// Package: shared types and constants of the biquad dry/wet mixer.
package bqmix_pkg;

    localparam int COEF_W    = 24;
    localparam int NUM_REGS  = 7;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_COEF_X0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_X1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_X2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_Y1  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_Y2  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WET_GAIN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DRY_GAIN = 3'd6;

    localparam logic signed [COEF_W-1:0] COEF_X0_RST  = 24'sd2097152;
    localparam logic signed [COEF_W-1:0] DRY_GAIN_RST = 24'sd2097152;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A0,
        ST_A1,
        ST_A2,
        ST_B1,
        ST_B2,
        ST_DRY,
        ST_Z,
        ST_WET,
        ST_MSUM,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_A0_X,
        MUL_A1_X1,
        MUL_A2_X2,
        MUL_B1_Y1,
        MUL_B2_Y2,
        MUL_DRY_X,
        MUL_WET_Z
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_ADD,
        ACC_SUB,
        ACC_RND,
        ACC_RND_P
    } acc_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     load_in;
        logic     z_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

[rtl/core/bqmix_ctrl.sv]
// Controller: sequences the shared multiplier and accumulator for one word.
module bqmix_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bqmix_pkg::status_t status,
    output bqmix_pkg::cmd_t    cmd
);

    bqmix_pkg::state_t state_reg;
    bqmix_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bqmix_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bqmix_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bqmix_pkg::ST_A0;
                end
            end
            bqmix_pkg::ST_A0:   state_next = bqmix_pkg::ST_A1;
            bqmix_pkg::ST_A1:   state_next = bqmix_pkg::ST_A2;
            bqmix_pkg::ST_A2:   state_next = bqmix_pkg::ST_B1;
            bqmix_pkg::ST_B1:   state_next = bqmix_pkg::ST_B2;
            bqmix_pkg::ST_B2:   state_next = bqmix_pkg::ST_DRY;
            bqmix_pkg::ST_DRY:  state_next = bqmix_pkg::ST_Z;
            bqmix_pkg::ST_Z:    state_next = bqmix_pkg::ST_WET;
            bqmix_pkg::ST_WET:  state_next = bqmix_pkg::ST_MSUM;
            bqmix_pkg::ST_MSUM: state_next = bqmix_pkg::ST_OUT;
            bqmix_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = bqmix_pkg::ST_IDLE;
                end
            end
            default:            state_next = bqmix_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != bqmix_pkg::ST_IDLE);
        cmd.mul_sel  = bqmix_pkg::MUL_A0_X;
        cmd.acc_op   = bqmix_pkg::ACC_HOLD;
        cmd.load_in  = 1'b0;
        cmd.z_load   = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            bqmix_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.acc_op  = bqmix_pkg::ACC_RND;
                end
            end
            bqmix_pkg::ST_A0:
            begin
                cmd.mul_sel = bqmix_pkg::MUL_A0_X;
            end
            bqmix_pkg::ST_A1:
            begin
                cmd.mul_sel = bqmix_pkg::MUL_A1_X1;
                cmd.acc_op  = bqmix_pkg::ACC_ADD;
            end
            bqmix_pkg::ST_A2:
            begin
                cmd.mul_sel = bqmix_pkg::MUL_A2_X2;
                cmd.acc_op  = bqmix_pkg::ACC_ADD;
            end
            bqmix_pkg::ST_B1:
            begin
                cmd.mul_sel = bqmix_pkg::MUL_B1_Y1;
                cmd.acc_op  = bqmix_pkg::ACC_ADD;
            end
            bqmix_pkg::ST_B2:
            begin
                cmd.mul_sel = bqmix_pkg::MUL_B2_Y2;
                cmd.acc_op  = bqmix_pkg::ACC_SUB;
            end
            bqmix_pkg::ST_DRY:
            begin
                cmd.mul_sel = bqmix_pkg::MUL_DRY_X;
                cmd.acc_op  = bqmix_pkg::ACC_SUB;
            end
            bqmix_pkg::ST_Z:
            begin
                cmd.z_load = 1'b1;
                cmd.acc_op = bqmix_pkg::ACC_RND_P;
            end
            bqmix_pkg::ST_WET:
            begin
                cmd.mul_sel = bqmix_pkg::MUL_WET_Z;
            end
            bqmix_pkg::ST_MSUM:
            begin
                cmd.acc_op = bqmix_pkg::ACC_ADD;
            end
            bqmix_pkg::ST_OUT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd.acc_op = bqmix_pkg::ACC_HOLD;
            end
        endcase
    end

endmodule

[rtl/core/bqmix_dp.sv]
// Datapath: coefficient registers, channel history, shared multiplier, accumulator, output word.
module bqmix_dp #(
    parameter int CHANNELS       = 2,
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 21
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bqmix_pkg::cmd_t                      cmd,
    output bqmix_pkg::status_t                   status,
    input  logic                                 cfg_we,
    input  logic [bqmix_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [bqmix_pkg::COEF_W-1:0]         cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    input  logic                                 channel,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    output logic                                 channel_out
);

    localparam int CW = bqmix_pkg::COEF_W;
    localparam int PW = CW + SAMPLE_WIDTH;
    localparam int AW = PW + 3;
    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic signed [AW-1:0] RND = AW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [CW-1:0]           coef_reg [bqmix_pkg::NUM_REGS];
    logic signed [SAMPLE_WIDTH-1:0] xh1_reg  [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] xh2_reg  [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] yh1_reg  [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] yh2_reg  [CHANNELS];

    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic                           ch_reg, ch_next;
    logic signed [SAMPLE_WIDTH-1:0] z_reg, z_next;
    logic signed [PW-1:0]           prod_reg, prod_next;
    logic signed [AW-1:0]           acc_reg, acc_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg, sample_out_next;
    logic                           ch_out_reg, ch_out_next;

    logic [IW-1:0]                  hidx;
    logic signed [CW-1:0]           mul_a;
    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic signed [AW-1:0]           prod_ext;
    logic signed [AW-1:0]           acc_sh;
    logic [AW-SAMPLE_WIDTH:0]       acc_top;
    logic                           acc_ovf;
    logic signed [SAMPLE_WIDTH-1:0] acc_sat;

    assign hidx = (CHANNELS > 1) ? IW'(ch_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bqmix_pkg::NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
            coef_reg[bqmix_pkg::REG_COEF_X0]  <= bqmix_pkg::COEF_X0_RST;
            coef_reg[bqmix_pkg::REG_DRY_GAIN] <= bqmix_pkg::DRY_GAIN_RST;
        end
        else if (cfg_we && (cfg_index <= bqmix_pkg::REG_DRY_GAIN))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // shift history of the active channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                xh1_reg[i] <= '0;
                xh2_reg[i] <= '0;
                yh1_reg[i] <= '0;
                yh2_reg[i] <= '0;
            end
        end
        else if (cmd.z_load)
        begin
            xh2_reg[hidx] <= xh1_reg[hidx];
            xh1_reg[hidx] <= x_reg;
            yh2_reg[hidx] <= yh1_reg[hidx];
            yh1_reg[hidx] <= acc_sat;
        end
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            bqmix_pkg::MUL_A0_X:
            begin
                mul_a = coef_reg[bqmix_pkg::REG_COEF_X0];
                mul_b = x_reg;
            end
            bqmix_pkg::MUL_A1_X1:
            begin
                mul_a = coef_reg[bqmix_pkg::REG_COEF_X1];
                mul_b = xh1_reg[hidx];
            end
            bqmix_pkg::MUL_A2_X2:
            begin
                mul_a = coef_reg[bqmix_pkg::REG_COEF_X2];
                mul_b = xh2_reg[hidx];
            end
            bqmix_pkg::MUL_B1_Y1:
            begin
                mul_a = coef_reg[bqmix_pkg::REG_COEF_Y1];
                mul_b = yh1_reg[hidx];
            end
            bqmix_pkg::MUL_B2_Y2:
            begin
                mul_a = coef_reg[bqmix_pkg::REG_COEF_Y2];
                mul_b = yh2_reg[hidx];
            end
            bqmix_pkg::MUL_DRY_X:
            begin
                mul_a = coef_reg[bqmix_pkg::REG_DRY_GAIN];
                mul_b = x_reg;
            end
            bqmix_pkg::MUL_WET_Z:
            begin
                mul_a = coef_reg[bqmix_pkg::REG_WET_GAIN];
                mul_b = z_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);
    assign prod_ext  = AW'(prod_reg);

    always_comb
    begin
        unique case (cmd.acc_op)
            bqmix_pkg::ACC_HOLD:  acc_next = acc_reg;
            bqmix_pkg::ACC_ADD:   acc_next = acc_reg + prod_ext;
            bqmix_pkg::ACC_SUB:   acc_next = acc_reg - prod_ext;
            bqmix_pkg::ACC_RND:   acc_next = RND;
            bqmix_pkg::ACC_RND_P: acc_next = RND + prod_ext;
            default:              acc_next = acc_reg;
        endcase
    end

    // round (offset already in the accumulator) and saturate
    assign acc_sh  = acc_reg >>> COEF_FRAC_BITS;
    assign acc_top = acc_sh[AW-1:SAMPLE_WIDTH-1];
    assign acc_ovf = !((&acc_top) || !(|acc_top));
    assign acc_sat = acc_ovf ? (acc_sh[AW-1] ? S_MIN : S_MAX) : acc_sh[SAMPLE_WIDTH-1:0];

    assign x_next  = cmd.load_in ? sample_in : x_reg;
    assign ch_next = cmd.load_in ? channel : ch_reg;
    assign z_next  = cmd.z_load ? acc_sat : z_reg;

    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        ch_out_next     = ch_out_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            sample_out_next = acc_sat;
            ch_out_next     = ch_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        ch_reg         <= ch_next;
        z_reg          <= z_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        sample_out_reg <= sample_out_next;
        ch_out_reg     <= ch_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign channel_out = ch_out_reg;

endmodule

[rtl/core/biquad_filter_dry_wet_mix_top.sv]
// Top level of the per-channel biquad filter with dry/wet mix.
// Each accepted word (sample_in, channel) runs through a direct form I biquad
// using that channel's two past inputs and two past filter outputs; the filter
// output is rounded and saturated before it is stored, and the result word is
// round(dry*x + wet*z) saturated to SAMPLE_WIDTH bits. A word passes the accept
// step, seven products through the single shared 24 x SAMPLE_WIDTH multiplier
// with its accumulator, and the rounding and output steps. A finished word waits
// in the output register while the next input word is taken. Coefficients are
// signed with COEF_FRAC_BITS fraction bits and are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. An index past dry_gain is ignored.
module biquad_filter_dry_wet_mix_top #(
    parameter int CHANNELS       = 2,
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 21
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    input  logic                                 channel,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    output logic                                 channel_out,
    input  logic                                 cfg_we,
    input  logic [bqmix_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [bqmix_pkg::COEF_W-1:0]         cfg_data
);

    bqmix_pkg::cmd_t    cmd;
    bqmix_pkg::status_t status;

    bqmix_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bqmix_dp #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_in   (sample_in),
        .channel     (channel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .channel_out (channel_out)
    );

endmodule

[rtl/core/bqmix_chk.sv]
// Checker: port-level assertions on the biquad mixer, bound to the top level.
`include "assert_macros.svh"

module bqmix_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall
);

    `CHK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `CHK_NEXT(a_no_early_result, in_valid && !in_stall && !out_valid, !out_valid)
    `CHK_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall))
    `CHK_NEXT(a_out_held, out_valid && out_stall, out_valid)

endmodule

bind biquad_filter_dry_wet_mix_top bqmix_chk u_bqmix_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
